[sv/assert_macros.svh]
// Assertion helpers for the interval ranking block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[sv/icfr_pkg.sv]
// ----------------------------------------------------------------------------
// icfr_pkg
// Shared types and constants for the interval ranking block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package icfr_pkg;
    localparam int POS_W = 24;
    localparam int THR_W = 23;
    localparam int TAG_W = 4;
    localparam int ROOM_W = 26;
    localparam logic [THR_W-1:0] THR_RESET = 23'd768;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [ROOM_W-1:0] room_t;

    // one loaded candidate, passed from the front end to the ranking engine
    typedef struct packed {
        pos_t              low;
        pos_t              high;
        pos_t              lim_low;
        pos_t              lim_high;
        pos_t              guide;
        logic              last;
    } cand_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FILTER,
        ST_SORT,
        ST_EMIT,
        ST_NONE
    } state_t;

    function automatic room_t room_of(pos_t lo, pos_t hi, pos_t wl, pos_t wh);
        pos_t h;
        pos_t l;
        h = (hi < wh) ? hi : wh;
        l = (lo > wl) ? lo : wl;
        return room_t'(h) - room_t'(l);
    endfunction

    function automatic logic holds(pos_t lo, pos_t hi, pos_t g);
        return (hi >= g) && (lo <= g);
    endfunction
endpackage

[sv/icfr_fifo.sv]
// ----------------------------------------------------------------------------
// icfr_fifo
// Short queue decoupling the input front end from the ranking engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module icfr_fifo
    import icfr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  cand_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output cand_t out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cand_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push) begin
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

    `ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= (AW+1)'(DEPTH), "fifo overflow")
    `ASSERT_NEXT(a_push_only, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1,
        "fifo count")
    `ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1,
        "fifo count")
endmodule

[sv/icfr_engine.sv]
// ----------------------------------------------------------------------------
// icfr_engine
// Stores candidates, filters against the window, bubble-sorts and emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module icfr_engine
    import icfr_pkg::*;
#(
    parameter int MAX_CHOICES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [THR_W-1:0]  thr,
    input  logic              in_valid,
    output logic              in_ready,
    input  cand_t             in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TAG_W-1:0]  out_tag,
    output pos_t              out_low,
    output pos_t              out_high,
    output logic              out_none,
    output logic              out_last
);
    localparam int IW = $clog2(MAX_CHOICES);
    localparam int CW = IW + 1;

    pos_t              low_reg  [MAX_CHOICES];
    pos_t              high_reg [MAX_CHOICES];
    logic [TAG_W-1:0]  tag_reg  [MAX_CHOICES];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     i_reg, i_next;
    logic              swp_reg, swp_next;
    pos_t              wl_reg, wh_reg, g_reg;
    state_t            st_reg, st_next;

    logic              ov_reg;
    logic [TAG_W-1:0]  otag_reg;
    pos_t              olow_reg, ohigh_reg;
    logic              onone_reg, olast_reg;
    logic              out_free, emit;
    logic [IW-1:0]     ia, ib, il;
    room_t             ra, rb;
    logic              do_swap, drop, accept;

    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (st_reg == ST_LOAD);
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_tag   = otag_reg;
    assign out_low   = olow_reg;
    assign out_high  = ohigh_reg;
    assign out_none  = onone_reg;
    assign out_last  = olast_reg;

    assign ia = i_reg[IW-1:0];
    assign ib = IW'(i_reg + 1'b1);
    assign il = IW'(cnt_reg - 1'b1);
    assign ra = room_of(low_reg[ia], high_reg[ia], wl_reg, wh_reg);
    assign rb = room_of(low_reg[ib], high_reg[ib], wl_reg, wh_reg);
    assign drop = (low_reg[ia] > wh_reg) || (high_reg[ia] < wl_reg);

    always_comb begin
        if (ra < room_t'({1'b0, thr}) || rb < room_t'({1'b0, thr})) begin
            do_swap = (ra < rb);
        end else begin
            do_swap = !holds(low_reg[ia], high_reg[ia], g_reg)
                   && holds(low_reg[ib], high_reg[ib], g_reg);
        end
    end

    always_comb begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        i_next   = i_reg;
        swp_next = swp_reg;
        emit     = 1'b0;
        case (st_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (cnt_reg < CW'(MAX_CHOICES)) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (in_data.last) begin
                        st_next = ST_FILTER;
                        i_next  = '0;
                    end
                end
            end
            ST_FILTER: begin
                if (i_reg >= cnt_reg) begin
                    st_next  = ST_SORT;
                    i_next   = '0;
                    swp_next = 1'b0;
                    if (cnt_reg == '0) begin
                        st_next = ST_NONE;
                    end
                end else if (drop) begin
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_SORT: begin
                if (i_reg + 1'b1 >= cnt_reg) begin
                    i_next   = '0;
                    swp_next = 1'b0;
                    if (!swp_reg) begin
                        st_next = ST_EMIT;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                    if (do_swap) begin
                        swp_next = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == cnt_reg) begin
                        st_next  = ST_LOAD;
                        cnt_next = '0;
                        i_next   = '0;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    st_next = ST_LOAD;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_LOAD;
            cnt_reg <= '0;
            i_reg   <= '0;
            swp_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            i_reg   <= i_next;
            swp_reg <= swp_next;
            if (emit) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && cnt_reg < CW'(MAX_CHOICES)) begin
            low_reg[cnt_reg[IW-1:0]]  <= in_data.low;
            high_reg[cnt_reg[IW-1:0]] <= in_data.high;
            tag_reg[cnt_reg[IW-1:0]]  <= TAG_W'(cnt_reg);
        end
        if (accept && in_data.last) begin
            wl_reg <= in_data.lim_low;
            wh_reg <= in_data.lim_high;
            g_reg  <= in_data.guide;
        end
        if (st_reg == ST_FILTER && i_reg < cnt_reg && drop) begin
            low_reg[ia]  <= low_reg[il];
            high_reg[ia] <= high_reg[il];
            tag_reg[ia]  <= tag_reg[il];
        end
        if (st_reg == ST_SORT && i_reg + 1'b1 < cnt_reg && do_swap) begin
            low_reg[ia]  <= low_reg[ib];
            high_reg[ia] <= high_reg[ib];
            tag_reg[ia]  <= tag_reg[ib];
            low_reg[ib]  <= low_reg[ia];
            high_reg[ib] <= high_reg[ia];
            tag_reg[ib]  <= tag_reg[ia];
        end
        if (emit) begin
            if (st_reg == ST_NONE) begin
                otag_reg  <= '0;
                olow_reg  <= '0;
                ohigh_reg <= '0;
                onone_reg <= 1'b1;
                olast_reg <= 1'b1;
            end else begin
                otag_reg  <= tag_reg[ia];
                olow_reg  <= low_reg[ia];
                ohigh_reg <= high_reg[ia];
                onone_reg <= 1'b0;
                olast_reg <= (i_reg + 1'b1 == cnt_reg);
            end
        end
    end

    `ASSERT_IMPL(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg <= CW'(MAX_CHOICES), "count overflow")
    `ASSERT_IMPL(a_emit_free, aclk, aresetn, emit, out_free, "result overwritten")
    `ASSERT_NEXT(a_none_last, aclk, aresetn, emit && st_reg == ST_NONE,
        out_none && out_last && out_valid, "empty set result malformed")
endmodule

[sv/interval_choice_filter_rank.sv]
// ----------------------------------------------------------------------------
// interval_choice_filter_rank
// Loads candidate intervals, drops those outside the window, ranks the rest.
// ----------------------------------------------------------------------------
// Usage: each s_ transaction carries one candidate; the transaction with
// s_axis_tlast high also supplies window and guide and ends the set. The
// m_ channel returns the ranked survivors in order, m_axis_tlast on the
// final one, or a single transaction with none_valid set (in tuser).
// After the last candidate the engine filters the store, then bubble sorts
// it in passes until a pass makes no swap (one neighbour compare per cycle
// in the shared compare unit), then emits the results in order. The store
// holds at most MAX_CHOICES candidates. A two-entry queue in front takes
// up to two further candidates while the engine is ranking.
// Reset empties queue and store and sets the threshold to 3.0 m.
// A stalled receiver holds the current result; ranking pauses at emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module interval_choice_filter_rank
    import icfr_pkg::*;
#(
    parameter int MAX_CHOICES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [22:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // choice_low, choice_high, limit_low, limit_high, guide_pos
    input  logic [119:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rank_index, ranked_low, ranked_high, 4 zero bits
    output logic [55:0]  m_axis_tdata,
    // none_valid
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    logic [THR_W-1:0] thr_reg;
    cand_t fin, fout;
    logic fv, fr;
    logic [TAG_W-1:0] tag;
    pos_t lo, hi;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    assign fin.low      = s_axis_tdata[23:0];
    assign fin.high     = s_axis_tdata[47:24];
    assign fin.lim_low  = s_axis_tdata[71:48];
    assign fin.lim_high = s_axis_tdata[95:72];
    assign fin.guide    = s_axis_tdata[119:96];
    assign fin.last     = s_axis_tlast;

    icfr_fifo #(.DEPTH(2)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(fin),
        .out_valid(fv), .out_ready(fr), .out_data(fout)
    );

    icfr_engine #(.MAX_CHOICES(MAX_CHOICES)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .thr(thr_reg),
        .in_valid(fv), .in_ready(fr), .in_data(fout),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_tag(tag), .out_low(lo), .out_high(hi),
        .out_none(m_axis_tuser), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, hi, lo, tag};
endmodule

[dv/interval_rank_checker.sv]
// ----------------------------------------------------------------------------
// interval_rank_checker
// Watches both stream channels of the interval ranking block, keeps its own
// copy of the candidate store and threshold, ranks each completed set and
// compares every result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module interval_rank_checker
    import icfr_pkg::*;
#(
    parameter int MAX_CHOICES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [22:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending
);
    typedef struct packed {
        logic [3:0] tag;
        pos_t       low;
        pos_t       high;
        logic       none;
        logic       last;
    } ranked_t;

    ranked_t     ranked_q[$];
    pos_t        set_low[MAX_CHOICES];
    pos_t        set_high[MAX_CHOICES];
    logic [3:0]  set_tag[MAX_CHOICES];
    int          set_n;
    logic [22:0] thr_shadow;

    function automatic logic signed [25:0] room(pos_t lo, pos_t hi, pos_t wl, pos_t wh);
        logic signed [25:0] h;
        logic signed [25:0] l;
        h = (hi < wh) ? hi : wh;
        l = (lo > wl) ? lo : wl;
        return h - l;
    endfunction

    task automatic swap_cand(int a, int b);
        pos_t       tl;
        pos_t       th;
        logic [3:0] tt;
        tl = set_low[a]; th = set_high[a]; tt = set_tag[a];
        set_low[a] = set_low[b]; set_high[a] = set_high[b]; set_tag[a] = set_tag[b];
        set_low[b] = tl; set_high[b] = th; set_tag[b] = tt;
    endtask

    task automatic rank_set(pos_t wl, pos_t wh, pos_t g);
        int n;
        int i;
        logic swapped;
        logic signed [25:0] ra;
        logic signed [25:0] rb;
        logic signed [25:0] thr;
        logic ga;
        logic gb;
        ranked_t r;
        thr = {3'b000, thr_shadow};
        n = set_n;
        i = 0;
        while (i < n) begin
            if (set_low[i] > wh || set_high[i] < wl) begin
                if (i != n - 1) swap_cand(i, n - 1);
                n--;
            end else begin
                i++;
            end
        end
        for (int p = 0; p < n; p++) begin
            swapped = 1'b0;
            for (i = 0; i + 1 < n; i++) begin
                ra = room(set_low[i], set_high[i], wl, wh);
                rb = room(set_low[i+1], set_high[i+1], wl, wh);
                if (ra < thr || rb < thr) begin
                    if (ra < rb) begin
                        swap_cand(i, i + 1);
                        swapped = 1'b1;
                    end
                end else begin
                    ga = (set_high[i] >= g) && (set_low[i] <= g);
                    gb = (set_high[i+1] >= g) && (set_low[i+1] <= g);
                    if (!ga && gb) begin
                        swap_cand(i, i + 1);
                        swapped = 1'b1;
                    end
                end
            end
            if (!swapped) break;
        end
        set_n = 0;
        if (n == 0) begin
            r = '0;
            r.none = 1'b1;
            r.last = 1'b1;
            ranked_q = {ranked_q, r};
        end
        for (i = 0; i < n; i++) begin
            r.tag = set_tag[i];
            r.low = set_low[i];
            r.high = set_high[i];
            r.none = 1'b0;
            r.last = (i == n - 1);
            ranked_q = {ranked_q, r};
        end
    endtask

    always @(posedge aclk) begin
        ranked_t exp_r;
        ranked_t got;
        int      n_err;
        if (!aresetn) begin
            set_n <= 0;
            thr_shadow <= THR_RESET;
            fail_count <= 0;
            pending <= 0;
            ranked_q.delete();
        end else begin
            n_err = 0;
            if (cfg_wr_en) thr_shadow = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (set_n < MAX_CHOICES) begin
                    set_low[set_n] = s_axis_tdata[23:0];
                    set_high[set_n] = s_axis_tdata[47:24];
                    set_tag[set_n] = set_n[3:0];
                    set_n++;
                end
                if (s_axis_tlast)
                    rank_set(s_axis_tdata[71:48], s_axis_tdata[95:72], s_axis_tdata[119:96]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.tag = m_axis_tdata[3:0];
                got.low = m_axis_tdata[27:4];
                got.high = m_axis_tdata[51:28];
                got.none = m_axis_tuser;
                got.last = m_axis_tlast;
                if (ranked_q.size() == 0) begin
                    $error("unexpected result transaction %h", m_axis_tdata);
                    n_err++;
                end else begin
                    exp_r = ranked_q.pop_front();
                    if (got.tag !== exp_r.tag) begin
                        $error("rank_index: expected %0d actual %0d", exp_r.tag, got.tag);
                        n_err++;
                    end
                    if (got.low !== exp_r.low) begin
                        $error("ranked_low: expected %0d actual %0d", exp_r.low, got.low);
                        n_err++;
                    end
                    if (got.high !== exp_r.high) begin
                        $error("ranked_high: expected %0d actual %0d", exp_r.high, got.high);
                        n_err++;
                    end
                    if (got.none !== exp_r.none) begin
                        $error("none_valid: expected %0b actual %0b", exp_r.none, got.none);
                        n_err++;
                    end
                    if (got.last !== exp_r.last) begin
                        $error("last_out: expected %0b actual %0b", exp_r.last, got.last);
                        n_err++;
                    end
                end
            end
            fail_count <= fail_count + n_err;
            pending <= ranked_q.size();
        end
    end
endmodule

[dv/interval_choice_filter_rank_tb.sv]
// ----------------------------------------------------------------------------
// interval_choice_filter_rank_tb
// Drives candidate sets through the interval ranking block under several
// threshold settings and idling phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module interval_choice_filter_rank_tb;
    import icfr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [22:0]  cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           cycle_count = 0;
    int           items_sent;
    int           set_items;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    interval_choice_filter_rank u_dut (.*);

    interval_rank_checker u_chk (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic pos_t rnd_pos();
        case ($urandom_range(5))
            0: return pos_t'($urandom);
            1: return 24'sh7FFFFF - pos_t'($urandom_range(3));
            2: return 24'sh800000 + pos_t'($urandom_range(3));
            default: return pos_t'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // tvalid stays high between back-to-back transactions
    task automatic send(pos_t lo, pos_t hi, pos_t wl, pos_t wh, pos_t g, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tdata <= {g, wh, wl, hi, lo};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // mostly overlapping candidates around the window, some outside or inverted
    task automatic random_set(int n);
        pos_t wl;
        pos_t wh;
        pos_t g;
        pos_t lo;
        pos_t hi;
        wl = pos_t'($signed($urandom_range(2000)) - 1500);
        wh = wl + pos_t'($urandom_range(3000));
        if ($urandom_range(9) == 0) begin
            wl = rnd_pos();
            wh = rnd_pos();
        end
        g = wl + pos_t'($urandom_range(3000));
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 2) begin
                lo = rnd_pos();
                hi = rnd_pos();
            end else begin
                lo = pos_t'($signed($urandom_range(5000)) - 2500);
                hi = lo + pos_t'($signed($urandom_range(2000)) - 100);
            end
            send(lo, hi, wl, wh, g, k == n - 1);
        end
    endtask

    task automatic drain_and_cfg(logic [22:0] thr);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        cfg_wr_data <= thr;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: single, none valid, extremes, guide ties, overfull store
        send(24'sd0, 24'sd1000, -24'sd100, 24'sd500, 24'sd10, 1'b1);
        send(24'sd600, 24'sd700, -24'sd100, 24'sd500, 24'sd0, 1'b0);
        send(-24'sd900, -24'sd200, -24'sd100, 24'sd500, 24'sd0, 1'b1);
        send(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
        send(24'sd0, 24'sd2000, 24'sh800000, 24'sh7FFFFF, 24'sd0, 1'b1);
        send(24'sd0, 24'sd1000, 24'sd0, 24'sd5000, 24'sd1500, 1'b0);
        send(24'sd1000, 24'sd2000, 24'sd0, 24'sd5000, 24'sd1500, 1'b0);
        send(24'sd0, 24'sd100, 24'sd0, 24'sd5000, 24'sd1500, 1'b1);
        send(24'sd500, 24'sd100, 24'sd1000, 24'sd0, 24'sd0, 1'b1);
        for (int k = 0; k < 18; k++)
            send(pos_t'(k * 100), pos_t'(k * 150 + 50), 24'sd0, 24'sd2000, 24'sd900, k == 17);
        drain_and_cfg(23'd0);
        items_sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            items_sent = 0;
            while (items_sent < 56) begin
                set_items = ($urandom_range(9) == 0) ? $urandom_range(15, 17)
                                                     : $urandom_range(1, 6);
                random_set(set_items);
                items_sent += set_items;
            end
            case (ph)
                0: drain_and_cfg(23'h7FFFFF);
                1: drain_and_cfg(23'd768);
                2: drain_and_cfg(23'd1);
                default: drain_and_cfg(23'($urandom_range(2000)));
            endcase
        end
        recv_stall_pct = 0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/icfr_pkg.sv
sv/icfr_fifo.sv
sv/icfr_engine.sv
sv/interval_choice_filter_rank.sv
dv/interval_rank_checker.sv
dv/interval_choice_filter_rank_tb.sv
